FILE: hdl/biq_pkg.sv
// Shared types and constants for the biquad filter core.
`default_nettype none
package biq_pkg;

   localparam int COEF_WIDTH          = 18;
   localparam int CSR_INDEX_WIDTH     = 3;
   localparam int SAMPLE_WIDTH_DEF    = 16;
   localparam int COEF_FRAC_BITS_DEF  = 16;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      COEF_B0 = 3'd0,
      COEF_B1 = 3'd1,
      COEF_B2 = 3'd2,
      COEF_A1 = 3'd3,
      COEF_A2 = 3'd4
   } coef_index_type;

   typedef struct packed {
      logic signed [COEF_WIDTH-1:0] b0;
      logic signed [COEF_WIDTH-1:0] b1;
      logic signed [COEF_WIDTH-1:0] b2;
      logic signed [COEF_WIDTH-1:0] a1;
      logic signed [COEF_WIDTH-1:0] a2;
   } coef_set_type;

endpackage
`default_nettype wire

FILE: hdl/biq_coef_regs.sv
// Coefficient register file with history clear on every write to a mapped index.
`default_nettype none
module biq_coef_regs #(
   parameter int COEF_FRAC_BITS = biq_pkg::COEF_FRAC_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [biq_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [biq_pkg::COEF_WIDTH-1:0]       csr_data,
   output biq_pkg::coef_set_type                     coefs,
   output logic                                      hist_clear
);
   import biq_pkg::*;

   localparam logic [COEF_WIDTH-1:0] B0_RESET = COEF_WIDTH'(64'd1 << COEF_FRAC_BITS);

   coef_set_type coef_ff;
   coef_set_type coef_in;
   logic         hit;

   assign csr_ready = 1'b1;

   always_comb begin
      coef_in = coef_ff;
      hit     = 1'b0;
      if (csr_valid) begin
         case (coef_index_type'(csr_index))
            COEF_B0: begin coef_in.b0 = csr_data; hit = 1'b1; end
            COEF_B1: begin coef_in.b1 = csr_data; hit = 1'b1; end
            COEF_B2: begin coef_in.b2 = csr_data; hit = 1'b1; end
            COEF_A1: begin coef_in.a1 = csr_data; hit = 1'b1; end
            COEF_A2: begin coef_in.a2 = csr_data; hit = 1'b1; end
            default: hit = 1'b0;  // unmapped index: drop the write
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.b0 <= B0_RESET;
         coef_ff.b1 <= '0;
         coef_ff.b2 <= '0;
         coef_ff.a1 <= '0;
         coef_ff.a2 <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign coefs      = coef_ff;
   assign hist_clear = hit;

endmodule
`default_nettype wire

FILE: hdl/biq_mac.sv
// Five-tap multiply-accumulate with rounding and saturation.
`default_nettype none
module biq_mac #(
   parameter int SAMPLE_WIDTH   = biq_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEF_FRAC_BITS = biq_pkg::COEF_FRAC_BITS_DEF
) (
   input  biq_pkg::coef_set_type            coefs,
   input  wire logic signed [SAMPLE_WIDTH-1:0] x0,
   input  wire logic signed [SAMPLE_WIDTH-1:0] x1,
   input  wire logic signed [SAMPLE_WIDTH-1:0] x2,
   input  wire logic signed [SAMPLE_WIDTH-1:0] y1,
   input  wire logic signed [SAMPLE_WIDTH-1:0] y2,
   output logic signed [SAMPLE_WIDTH-1:0]      y0,
   output logic                                clipped
);
   import biq_pkg::*;

   localparam int PROD_W  = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int SUM_W   = PROD_W + 2;
   localparam int ACC_A   = SUM_W + 1;
   localparam int ACC_B   = COEF_FRAC_BITS + SAMPLE_WIDTH + 1;
   localparam int ACC_W   = (ACC_A > ACC_B) ? ACC_A : ACC_B;
   localparam int SHIFT_W = ACC_W - COEF_FRAC_BITS;
   localparam int TOP_W   = SHIFT_W - SAMPLE_WIDTH + 1;

   localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(64'd1 << (COEF_FRAC_BITS - 1));
   localparam logic [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   logic signed [PROD_W-1:0]  p_b0, p_b1, p_b2, p_a1, p_a2;
   logic signed [ACC_W-1:0]   acc;
   logic signed [ACC_W-1:0]   acc_rnd;
   logic        [SHIFT_W-1:0] shifted;
   logic        [TOP_W-1:0]   top;
   logic                      ovf;

   assign p_b0 = coefs.b0 * x0;
   assign p_b1 = coefs.b1 * x1;
   assign p_b2 = coefs.b2 * x2;
   assign p_a1 = coefs.a1 * y1;
   assign p_a2 = coefs.a2 * y2;

   assign acc = {{(ACC_W-PROD_W){p_b0[PROD_W-1]}}, p_b0}
              + {{(ACC_W-PROD_W){p_b1[PROD_W-1]}}, p_b1}
              + {{(ACC_W-PROD_W){p_b2[PROD_W-1]}}, p_b2}
              - {{(ACC_W-PROD_W){p_a1[PROD_W-1]}}, p_a1}
              - {{(ACC_W-PROD_W){p_a2[PROD_W-1]}}, p_a2};

   // round half up, then floor by the fraction width
   assign acc_rnd = acc + HALF_LSB;
   assign shifted = acc_rnd[ACC_W-1:COEF_FRAC_BITS];
   assign top     = shifted[SHIFT_W-1:SAMPLE_WIDTH-1];
   assign ovf     = !((&top) || !(|top));

   always_comb begin
      if (!ovf) begin
         y0 = shifted[SAMPLE_WIDTH-1:0];
      end else if (shifted[SHIFT_W-1]) begin
         y0 = SMIN;
      end else begin
         y0 = SMAX;
      end
   end

   assign clipped = ovf;

endmodule
`default_nettype wire

FILE: hdl/biquad_iir_filter_core.sv
// Top level of the direct form I biquad filter core.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------
//   req      | req_valid/req_ready  | req_sample_in
//   rsp      | rsp_valid/rsp_ready  | rsp_sample_out, rsp_clipped
//   csr      | csr_valid/csr_ready  | csr_index, csr_data
//
// A request is registered, then the five products, sum, rounding and
// saturation run combinationally into the result register, one request per
// cycle while results are taken; the y[n-1] feedback loop through the
// multiply-accumulate sets the cycle. Reset clears history and restores
// unity gain. A stalled result holds the input register; csr is always ready.
`default_nettype none
module biquad_iir_filter_core #(
   parameter int SAMPLE_WIDTH   = biq_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEF_FRAC_BITS = biq_pkg::COEF_FRAC_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [SAMPLE_WIDTH-1:0]       req_sample_in,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]            rsp_sample_out,
   output logic                                      rsp_clipped,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [biq_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [biq_pkg::COEF_WIDTH-1:0]       csr_data
);
   import biq_pkg::*;

   coef_set_type coefs;
   logic         hist_clear;

   logic                           in_valid_ff, in_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] in_sample_ff;
   logic signed [SAMPLE_WIDTH-1:0] x1_ff, x2_ff, y1_ff, y2_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_ff;
   logic                           rsp_clipped_ff;
   logic signed [SAMPLE_WIDTH-1:0] y_calc;
   logic                           clip_calc;
   logic                           advance;
   logic                           accept;

   biq_coef_regs #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
   ) u_coef (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .coefs      (coefs),
      .hist_clear (hist_clear)
   );

   biq_mac #(
      .SAMPLE_WIDTH  (SAMPLE_WIDTH),
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
   ) u_mac (
      .coefs   (coefs),
      .x0      (in_sample_ff),
      .x1      (x1_ff),
      .x2      (x2_ff),
      .y1      (y1_ff),
      .y2      (y2_ff),
      .y0      (y_calc),
      .clipped (clip_calc)
   );

   // move the staged request into the result register when it is free
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_sample_ff <= req_sample_in;
      end
      if (advance) begin
         rsp_sample_ff  <= y_calc;
         rsp_clipped_ff <= clip_calc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || hist_clear) begin
         x1_ff <= '0;
         x2_ff <= '0;
         y1_ff <= '0;
         y2_ff <= '0;
      end else if (advance) begin
         x1_ff <= in_sample_ff;
         x2_ff <= x1_ff;
         y1_ff <= y_calc;
         y2_ff <= y1_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_clipped    = rsp_clipped_ff;

endmodule
`default_nettype wire
